@@ sv/sgdm_pkg.sv @@
package sgdm_pkg;

  // Field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned RateW   = 16;
  localparam int unsigned DecayW  = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // Rate divider geometry
  localparam int unsigned NumW    = RateW + DecayW;          // base_rate << 24
  localparam int unsigned DenW    = DecayW + DataW + 1;      // 2^24 + decay*count
  localparam int unsigned DshW    = DenW + RateW - 1;        // denominator at top quotient bit
  localparam int unsigned StepW   = $clog2(RateW);

  localparam logic [RateW-1:0] BaseRateRst = RateW'(6554);
  localparam logic [DataW-1:0] CountTop    = {DataW{1'b1}};

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgBaseRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecay    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMomentum = 2'd2;

  // Item kinds
  localparam logic KindElem = 1'b0;
  localparam logic KindTick = 1'b1;

  // Queue depth
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_MUL,
    DS_DIV,
    DS_PUSH
  } div_state_e;

  typedef struct packed {
    logic                    kind;
    logic signed [DataW-1:0] gradient;
    logic signed [DataW-1:0] old_param;
    logic signed [DataW-1:0] old_momentum;
    logic [RateW-1:0]        rate;
  } item_t;

endpackage

@@ sv/sgd_momentum_update_core.sv @@
// Element items pass the queue, multiply stage and result register, one item
// per cycle sustained while the divider is idle and the output is not held.
// Ticks and writes run the rate divider, a multiply then the quotient bits;
// a tick's result is queued after that, and input is held off while it runs.
// Reset (rst_ni low, asynchronous): base_rate 6554, decay and momentum zero,
// iteration count zero, rate equal to base_rate, queue and pipeline empty.
module sgd_momentum_update_core #(
  parameter int unsigned QueueDepth = sgdm_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sgdm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sgdm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [sgdm_pkg::DataW-1:0] gradient_i,
  input  logic signed [sgdm_pkg::DataW-1:0] old_param_i,
  input  logic signed [sgdm_pkg::DataW-1:0] old_momentum_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sgdm_pkg::DataW-1:0] new_param_o,
  output logic signed [sgdm_pkg::DataW-1:0] new_momentum_o,
  output logic [sgdm_pkg::RateW-1:0]        rate_now_o
);
  import sgdm_pkg::*;

  logic             push, full, pop, empty;
  item_t            push_item, pop_item;
  logic [RateW-1:0] mom_factor;

  // Accept and classify items, keep the rate
  sgdm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .gradient_i        (gradient_i),
    .old_param_i       (old_param_i),
    .old_momentum_i    (old_momentum_i),
    .push_o            (push),
    .push_item_o       (push_item),
    .full_i            (full),
    .momentum_factor_o (mom_factor)
  );

  // Decouple front and back
  sgdm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  // Compute the update
  sgdm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .item_i            (pop_item),
    .pop_o             (pop),
    .momentum_factor_i (mom_factor),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .new_param_o       (new_param_o),
    .new_momentum_o    (new_momentum_o),
    .rate_now_o        (rate_now_o)
  );

endmodule

@@ sv/sgdm_fifo.sv @@
module sgdm_fifo #(
  parameter int unsigned Depth = sgdm_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sgdm_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sgdm_pkg::item_t pop_item_o
);
  import sgdm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

@@ sv/sgdm_front.sv @@
module sgdm_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sgdm_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [sgdm_pkg::CfgW-1:0]              cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   kind_i,
  input  logic signed [sgdm_pkg::DataW-1:0]      gradient_i,
  input  logic signed [sgdm_pkg::DataW-1:0]      old_param_i,
  input  logic signed [sgdm_pkg::DataW-1:0]      old_momentum_i,
  output logic                                   push_o,
  output sgdm_pkg::item_t                        push_item_o,
  input  logic                                   full_i,
  output logic [sgdm_pkg::RateW-1:0]             momentum_factor_o
);
  import sgdm_pkg::*;

  div_state_e          state_q, state_d;
  logic [RateW-1:0]    base_q, mom_q, rate_q, quo_q;
  logic [DecayW-1:0]   decay_q;
  logic [DataW-1:0]    count_q;
  logic                tick_q;
  logic [NumW-1:0]     rem_q;
  logic [DshW-1:0]     dsh_q;
  logic [StepW-1:0]    step_q;
  logic                accept, fits;
  logic [DenW-1:0]     denom;

  assign in_ready_o        = (state_q == DS_IDLE) && !full_i;
  assign accept            = in_valid_i && in_ready_o;
  assign momentum_factor_o = mom_q;
  assign denom = DenW'(decay_q) * DenW'(count_q) + (DenW'(1) << DecayW);
  assign fits  = ({{(DshW-NumW){1'b0}}, rem_q} >= dsh_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DS_IDLE: begin
        if (cfg_we_i && (cfg_idx_i == CfgBaseRate || cfg_idx_i == CfgDecay ||
                         cfg_idx_i == CfgMomentum)) begin
          state_d = DS_MUL;
        end else if (accept && kind_i == KindTick) begin
          state_d = DS_MUL;
        end
      end
      DS_MUL:  state_d = DS_DIV;
      DS_DIV: begin
        if (step_q == '0) begin
          state_d = tick_q ? DS_PUSH : DS_IDLE;
        end
      end
      DS_PUSH: begin
        if (!full_i) begin
          state_d = DS_IDLE;
        end
      end
      default: state_d = DS_IDLE;
    endcase
  end

  // Queue write: elements straight away, ticks once the rate is known
  always_comb begin
    push_o                   = 1'b0;
    push_item_o.kind         = KindElem;
    push_item_o.gradient     = gradient_i;
    push_item_o.old_param    = old_param_i;
    push_item_o.old_momentum = old_momentum_i;
    push_item_o.rate         = rate_q;
    case (state_q)
      DS_IDLE: push_o = accept && (kind_i == KindElem);
      DS_PUSH: begin
        push_o                   = 1'b1;
        push_item_o.kind         = KindTick;
        push_item_o.gradient     = '0;
        push_item_o.old_param    = '0;
        push_item_o.old_momentum = '0;
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      base_q  <= BaseRateRst;
      decay_q <= '0;
      mom_q   <= '0;
      count_q <= '0;
      rate_q  <= BaseRateRst;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == DS_IDLE) begin
        // Take register writes, then count ticks
        if (cfg_we_i) begin
          tick_q <= 1'b0;
          case (cfg_idx_i)
            CfgBaseRate: base_q  <= cfg_wdata_i[RateW-1:0];
            CfgDecay:    decay_q <= cfg_wdata_i[DecayW-1:0];
            CfgMomentum: mom_q   <= cfg_wdata_i[RateW-1:0];
            default:     mom_q   <= mom_q;
          endcase
        end else if (accept && kind_i == KindTick) begin
          tick_q <= 1'b1;
          if (count_q != CountTop) begin
            count_q <= count_q + 1'b1;
          end
        end
      end
      if (state_q == DS_DIV && step_q == '0) begin
        rate_q <= {quo_q[RateW-2:0], fits};
      end
    end
  end

  // Restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      DS_MUL: begin
        rem_q  <= {base_q, {DecayW{1'b0}}};
        dsh_q  <= {denom, {(RateW-1){1'b0}}};
        step_q <= StepW'(RateW - 1);
        quo_q  <= '0;
      end
      DS_DIV: begin
        if (fits) begin
          rem_q <= rem_q - dsh_q[NumW-1:0];
        end
        quo_q  <= {quo_q[RateW-2:0], fits};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - 1'b1;
      end
      default: step_q <= step_q;
    endcase
  end

endmodule

@@ sv/sgdm_back.sv @@
module sgdm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  sgdm_pkg::item_t                   item_i,
  output logic                              pop_o,
  input  logic [sgdm_pkg::RateW-1:0]        momentum_factor_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sgdm_pkg::DataW-1:0] new_param_o,
  output logic signed [sgdm_pkg::DataW-1:0] new_momentum_o,
  output logic [sgdm_pkg::RateW-1:0]        rate_now_o
);
  import sgdm_pkg::*;

  localparam int unsigned ProdW = DataW + RateW + 1;
  localparam int unsigned TermW = ProdW - RateW;

  logic                    v1_q, v2_q, en1, en2;
  logic                    kind1_q;
  logic signed [DataW-1:0] param1_q;
  logic signed [ProdW-1:0] mprod1_q, rprod1_q;
  logic [RateW-1:0]        rate1_q;
  logic signed [TermW:0]   upd_w;
  logic signed [DataW-1:0] upd_s;
  logic signed [DataW:0]   sum_w;
  logic signed [DataW-1:0] sum_s;

  assign en2   = !v2_q || out_ready_i;
  assign en1   = !v1_q || en2;
  assign pop_o = en1 && !empty_i;

  // Difference of floored terms, then saturated sum
  always_comb begin
    upd_w = (TermW+1)'(mprod1_q >>> RateW) - (TermW+1)'(rprod1_q >>> RateW);
    if (upd_w > (TermW+1)'($signed({1'b0, {(DataW-1){1'b1}}}))) begin
      upd_s = {1'b0, {(DataW-1){1'b1}}};
    end else if (upd_w < (TermW+1)'($signed({1'b1, {(DataW-1){1'b0}}}))) begin
      upd_s = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      upd_s = upd_w[DataW-1:0];
    end
    sum_w = (DataW+1)'(param1_q) + (DataW+1)'(upd_s);
    if (sum_w[DataW] != sum_w[DataW-1]) begin
      sum_s = {sum_w[DataW], {(DataW-1){!sum_w[DataW]}}};
    end else begin
      sum_s = sum_w[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= !empty_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Multiply stage, then result register
  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind1_q  <= item_i.kind;
      param1_q <= item_i.old_param;
      rate1_q  <= item_i.rate;
      mprod1_q <= $signed({1'b0, momentum_factor_i}) * item_i.old_momentum;
      rprod1_q <= $signed({1'b0, item_i.rate}) * item_i.gradient;
    end
    if (en2) begin
      rate_now_o <= rate1_q;
      if (kind1_q == KindTick) begin
        new_param_o    <= '0;
        new_momentum_o <= '0;
      end else begin
        new_param_o    <= sum_s;
        new_momentum_o <= upd_s;
      end
    end
  end

  assign out_valid_o = v2_q;

endmodule

@@ test/tb_sgd_momentum_update_core.sv @@
module tb_sgd_momentum_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sgdm_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] new_param;
    logic signed [DataW-1:0] new_momentum;
    logic [RateW-1:0]        rate_now;
  } update_t;

  // Tracks optimiser state and the updates still owed by the block
  class sgd_update_board;
    logic [RateW-1:0]  base_rate;
    logic [DecayW-1:0] decay;
    logic [RateW-1:0]  mom_factor;
    logic [DataW-1:0]  iter_count;
    logic [RateW-1:0]  rate;
    update_t           owed_q[$];
    int                mismatches;

    function new();
      base_rate  = BaseRateRst;
      decay      = '0;
      mom_factor = '0;
      iter_count = '0;
      rate       = BaseRateRst;
      mismatches = 0;
    endfunction

    function void refresh_rate();
      logic [63:0] num;
      logic [63:0] den;
      if (decay != '0) begin
        num  = {24'd0, base_rate, 24'd0};
        den  = 64'(1) << 24;
        den  = den + 64'(decay) * 64'(iter_count);
        rate = RateW'(num / den);
      end else begin
        rate = base_rate;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CfgBaseRate: base_rate = val[RateW-1:0];
        CfgDecay: decay = val[DecayW-1:0];
        CfgMomentum: mom_factor = val[RateW-1:0];
        default: return;
      endcase
      refresh_rate();
    endfunction

    function logic signed [DataW-1:0] clamp(logic signed [65:0] x);
      if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
      return x[DataW-1:0];
    endfunction

    // Work out the update an accepted item is owed
    function void note_item(logic kind, logic signed [DataW-1:0] grad,
                            logic signed [DataW-1:0] oldp, logic signed [DataW-1:0] oldm);
      update_t           u;
      logic signed [65:0] mom_term;
      logic signed [65:0] rate_term;
      logic signed [65:0] upd;
      if (kind == KindTick) begin
        if (iter_count != CountTop) iter_count = iter_count + 1;
        refresh_rate();
        u.new_param    = '0;
        u.new_momentum = '0;
      end else begin
        mom_term  = ($signed({1'b0, mom_factor}) * 66'(oldm)) >>> 16;
        rate_term = ($signed({1'b0, rate}) * 66'(grad)) >>> 16;
        upd       = 66'(clamp(mom_term - rate_term));
        u.new_momentum = upd[DataW-1:0];
        u.new_param    = clamp(66'(oldp) + upd);
      end
      u.rate_now = rate;
      owed_q.push_back(u);
    endfunction

    // Compare a delivered update with the oldest one owed
    function void check_update(logic signed [DataW-1:0] np, logic signed [DataW-1:0] nm,
                               logic [RateW-1:0] rn);
      update_t u;
      if (owed_q.size() == 0) begin
        $error("unexpected update: new_param %h new_momentum %h rate_now %h", np, nm, rn);
        mismatches++;
        return;
      end
      u = owed_q.pop_front();
      if (np !== u.new_param) begin
        $error("new_param: expected %h, got %h", u.new_param, np);
        mismatches++;
      end
      if (nm !== u.new_momentum) begin
        $error("new_momentum: expected %h, got %h", u.new_momentum, nm);
        mismatches++;
      end
      if (rn !== u.rate_now) begin
        $error("rate_now: expected %h, got %h", u.rate_now, rn);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgW-1:0]          cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     kind_i = KindElem;
  logic signed [DataW-1:0]  gradient_i = '0;
  logic signed [DataW-1:0]  old_param_i = '0;
  logic signed [DataW-1:0]  old_momentum_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DataW-1:0]  new_param_o;
  logic signed [DataW-1:0]  new_momentum_o;
  logic [RateW-1:0]         rate_now_o;

  sgd_update_board board = new();
  int  send_gap_max = 18;
  int  recv_gap_max = 18;
  bit  recv_hold = 1'b0;

  sgd_momentum_update_core u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Failsafe on a hung run
  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

  // Drain results with random stalls and the occasional long hold-off
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = recv_hold ? 400 : $urandom_range(recv_gap_max, 0);
      if (recv_hold) recv_hold <= 1'b0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_update(new_param_o, new_momentum_o, rate_now_o);
    end
  end

  // Offer one item after a random gap; hold it until accepted
  task automatic send_item(logic kind, logic [DataW-1:0] grad, logic [DataW-1:0] oldp,
                           logic [DataW-1:0] oldm);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    gradient_i     <= grad;
    old_param_i    <= oldp;
    old_momentum_i <= oldm;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(kind, grad, oldp, oldm);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // Write a register while idle, then let the rate divider finish
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(7, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'(signed'($urandom_range(200000, 0)) - 100000);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(9, 0) == 0) ? KindTick : KindElem,
                pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    logic [DataW-1:0] ext[4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: plain SGD, random ticks with decay off
    random_phase(100);
    wait_drained();

    // Extreme settings, then directed extremes of the fields
    write_reg(CfgBaseRate, 24'hFFFF);
    write_reg(CfgDecay, 24'hFF_FFFF);
    write_reg(CfgMomentum, 24'hFFFF);
    write_reg(2'd3, 24'h12_3456);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_item(KindElem, ext[i], ext[j], ext[3 - i]);
    send_item(KindTick, '0, '0, '0);
    send_item(KindTick, '1, '1, '1);
    send_item(KindElem, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_0000);
    wait_drained();

    // Long receiver hold-off while items keep coming, no sender gaps
    send_gap_max = 0;
    recv_hold    = 1'b1;
    random_phase(150);
    send_gap_max = 18;
    wait_drained();

    // All zero settings
    write_reg(CfgBaseRate, 24'h0);
    write_reg(CfgDecay, 24'h0);
    write_reg(CfgMomentum, 24'h0);
    recv_gap_max = 0;
    random_phase(120);
    recv_gap_max = 18;
    wait_drained();

    // Full rate and momentum, no decay
    write_reg(CfgBaseRate, 24'hFFFF);
    write_reg(CfgMomentum, 24'hFFFF);
    random_phase(150);
    wait_drained();

    // Random settings
    repeat (3) begin
      write_reg(CfgBaseRate, 24'($urandom()));
      write_reg(CfgDecay, ($urandom_range(1, 0) == 1) ? 24'($urandom())
                                                      : 24'($urandom_range(300, 1)));
      write_reg(CfgMomentum, 24'($urandom()));
      random_phase(110);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/sgdm_pkg.sv
sv/sgdm_fifo.sv
sv/sgdm_front.sv
sv/sgdm_back.sv
sv/sgd_momentum_update_core.sv
test/tb_sgd_momentum_update_core.sv
